### design/token_bucket_request_limiter_defines.svh
// Assertion macros shared by the limiter RTL.
`ifndef TOKEN_BUCKET_REQUEST_LIMITER_DEFINES_SVH
`define TOKEN_BUCKET_REQUEST_LIMITER_DEFINES_SVH

`ifndef ASSERT_OFF
// Check a property on every clock edge outside reset.
`define TBRL_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Check a property on every clock edge, reset included.
`define TBRL_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define TBRL_ASSERT(label, clk, rst, prop, msg)
`define TBRL_ASSERT_ALWAYS(label, clk, prop, msg)
`endif

`endif

### design/tbrl_pkg.sv
package tbrl_pkg;

  localparam int MILLI_PER_TOKEN = 1000;
  localparam int TOKEN_W         = 26;
  localparam int TIME_W          = 64;
  localparam int RATE_W          = 16;
  localparam int BURST_W         = 16;
  localparam int CFG_INDEX_W     = 8;
  localparam int PROD_W          = TOKEN_W + RATE_W;

  localparam logic [RATE_W-1:0]  RATE_RESET     = RATE_W'(10);
  localparam logic [TOKEN_W-1:0] CAPACITY_RESET = TOKEN_W'(20 * MILLI_PER_TOKEN);
  localparam logic [TOKEN_W-1:0] TOKEN_COST     = TOKEN_W'(MILLI_PER_TOKEN);

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_REFILL_RATE = CFG_INDEX_W'(0),
    REG_BURST_SIZE  = CFG_INDEX_W'(1)
  } tbrl_reg_t;

  // Active settings seen by the bucket.
  typedef struct packed {
    logic [RATE_W-1:0]  refill_rate;
    logic [TOKEN_W-1:0] capacity;
  } tbrl_cfg_t;

endpackage

### design/token_bucket_request_limiter.sv
// Pipeline: a request word passes through the input register, then the result
// register, which holds its result word.
// Throughput: one request per cycle while the result side does not stall; the
// refill multiply, clamp and take in the bucket update are combinational.
// Reset: synchronous, active high; settings return to rate 10 and burst 20,
// the bucket empties and waits for its first request to fill it.
`include "token_bucket_request_limiter_defines.svh"

module token_bucket_request_limiter (
  input  logic                                  clk,
  input  logic                                  rst,
  // Request stream.
  input  logic                                  s_tvalid,
  output logic                                  s_tready,
  input  logic [tbrl_pkg::TIME_W-1:0]           s_tdata,   // [63:0] time_ms
  // Result stream.
  output logic                                  m_tvalid,
  input  logic                                  m_tready,
  output logic [7:0]                            m_tdata,   // [0] allowed, [7:1] zero
  // Register write channel.
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [tbrl_pkg::CFG_INDEX_W-1:0]      cfg_index,
  input  logic [tbrl_pkg::BURST_W-1:0]          cfg_data
);

  tbrl_pkg::tbrl_cfg_t cfg;

  // Input register: holds one request word until the result register has room.
  logic                          stage_valid;
  logic [tbrl_pkg::TIME_W-1:0]   stage_time;

  // Result register: holds the decision until the downstream takes it.
  logic                          out_valid;
  logic                          out_allowed;

  logic advance;
  logic fire;
  logic allowed;

  // Move the staged word on whenever the result register is empty or draining.
  assign advance  = !out_valid || m_tready;
  assign fire     = stage_valid && advance;
  assign s_tready = !stage_valid || advance;

  tbrl_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // Update the bucket on the same edge the decision enters the result register.
  tbrl_bucket u_bucket (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .fire    (fire),
    .time_ms (stage_time),
    .allowed (allowed)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (s_tready) begin
      stage_valid <= s_tvalid;
    end
  end

  // Capture the payload only on accept; no reset needed.
  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      stage_time <= s_tdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= stage_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_allowed <= allowed;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {7'b0, out_allowed};

  `TBRL_ASSERT(a_stall_blocks_input, clk, rst, stage_valid && out_valid && !m_tready |-> !s_tready, "full pipeline must stall the request stream")
  `TBRL_ASSERT(a_result_has_source, clk, rst, $rose(out_valid) |-> $past(stage_valid), "result word appeared without a staged request")

endmodule

### design/tbrl_cfg.sv
module tbrl_cfg (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [tbrl_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [tbrl_pkg::BURST_W-1:0]        cfg_data,
  output tbrl_pkg::tbrl_cfg_t                 cfg
);

  logic [tbrl_pkg::RATE_W-1:0]  refill_rate;
  logic [tbrl_pkg::TOKEN_W-1:0] capacity;

  assign cfg_ready = 1'b1;

  // Store capacity in milli-tokens so the bucket path carries no multiply by 1000.
  always_ff @(posedge clk) begin
    if (rst) begin
      refill_rate <= tbrl_pkg::RATE_RESET;
      capacity    <= tbrl_pkg::CAPACITY_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        tbrl_pkg::REG_REFILL_RATE: begin
          refill_rate <= cfg_data;
        end
        tbrl_pkg::REG_BURST_SIZE: begin
          capacity <= tbrl_pkg::TOKEN_W'(cfg_data) * tbrl_pkg::TOKEN_COST;
        end
        default: begin
        end
      endcase
    end
  end

  assign cfg.refill_rate = refill_rate;
  assign cfg.capacity    = capacity;

endmodule

### design/tbrl_bucket.sv
`include "token_bucket_request_limiter_defines.svh"

module tbrl_bucket (
  input  logic                            clk,
  input  logic                            rst,
  input  tbrl_pkg::tbrl_cfg_t             cfg,
  input  logic                            fire,
  input  logic [tbrl_pkg::TIME_W-1:0]     time_ms,
  output logic                            allowed
);

  logic [tbrl_pkg::TOKEN_W-1:0] milli_tokens;
  logic [tbrl_pkg::TOKEN_W-1:0] milli_tokens_next;
  logic [tbrl_pkg::TIME_W-1:0]  last_update_ms;
  logic [tbrl_pkg::TIME_W-1:0]  last_update_ms_next;
  logic                         has_started;

  logic [tbrl_pkg::TIME_W-1:0]  elapsed;
  logic                         backwards;
  logic                         elapsed_big;
  logic [tbrl_pkg::PROD_W-1:0]  product;
  logic [tbrl_pkg::TOKEN_W-1:0] headroom;
  logic                         saturate;
  logic [tbrl_pkg::TOKEN_W-1:0] refilled;
  logic [tbrl_pkg::TOKEN_W-1:0] level;

  always_comb begin
    elapsed   = time_ms - last_update_ms;
    backwards = time_ms < last_update_ms;
    // Any elapsed time at or above 2^26 ms overfills even the largest bucket.
    elapsed_big = |elapsed[tbrl_pkg::TIME_W-1:tbrl_pkg::TOKEN_W];
    product     = tbrl_pkg::PROD_W'(elapsed[tbrl_pkg::TOKEN_W-1:0]) *
                  tbrl_pkg::PROD_W'(cfg.refill_rate);
    headroom    = cfg.capacity - milli_tokens;
    saturate    = (milli_tokens >= cfg.capacity) ||
                  ((cfg.refill_rate != '0) &&
                   (elapsed_big || (product >= tbrl_pkg::PROD_W'(headroom))));
    refilled    = saturate ? cfg.capacity
                           : milli_tokens + product[tbrl_pkg::TOKEN_W-1:0];

    if (!has_started) begin
      level               = cfg.capacity;
      last_update_ms_next = time_ms;
    end else if (backwards) begin
      level               = milli_tokens;
      last_update_ms_next = last_update_ms;
    end else begin
      level               = refilled;
      last_update_ms_next = time_ms;
    end

    allowed           = level >= tbrl_pkg::TOKEN_COST;
    milli_tokens_next = allowed ? level - tbrl_pkg::TOKEN_COST : level;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      milli_tokens   <= '0;
      last_update_ms <= '0;
      has_started    <= 1'b0;
    end else if (fire) begin
      milli_tokens   <= milli_tokens_next;
      last_update_ms <= last_update_ms_next;
      has_started    <= 1'b1;
    end
  end

  `TBRL_ASSERT(a_first_fill_full, clk, rst, fire && !has_started |=> milli_tokens == $past(cfg.capacity - (cfg.capacity >= tbrl_pkg::TOKEN_COST ? tbrl_pkg::TOKEN_COST : '0)), "first request must fill the bucket")
  `TBRL_ASSERT(a_backwards_keeps_time, clk, rst, fire && has_started && backwards |=> $stable(last_update_ms), "backward time must not move the stored time")
  `TBRL_ASSERT(a_allowed_takes_token, clk, rst, fire && allowed |=> milli_tokens == $past(level) - tbrl_pkg::TOKEN_COST, "an allowed request must take one token")

endmodule

### test/tb_token_bucket_request_limiter.sv
module tb_token_bucket_request_limiter;
  timeunit 1ns;
  timeprecision 1ps;

  // Register indexes that decode to nothing; writes there must leave the
  // settings alone.
  localparam logic [tbrl_pkg::CFG_INDEX_W-1:0] REG_SPARE_FIRST = tbrl_pkg::CFG_INDEX_W'(2);
  localparam logic [tbrl_pkg::CFG_INDEX_W-1:0] REG_SPARE_LAST  = '1;
  localparam int STALL_LIMIT = 2000;    // cycles with no word moving at all
  localparam int HOLD_CYCLES = 300;     // long result-side stall
  localparam int PHASE_WORDS = 80;

  logic                             clk;
  logic                             rst;
  logic                             s_tvalid;
  logic                             s_tready;
  logic [tbrl_pkg::TIME_W-1:0]      s_tdata;     // [63:0] time_ms
  logic                             m_tvalid;
  logic                             m_tready;
  logic [7:0]                       m_tdata;     // [0] allowed, [7:1] zero
  logic                             cfg_valid;
  logic                             cfg_ready;
  logic [tbrl_pkg::CFG_INDEX_W-1:0] cfg_index;
  logic [tbrl_pkg::BURST_W-1:0]     cfg_data;

  token_bucket_request_limiter u_top (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Bucket mirror: settings, content in milli-tokens, last refill time and
  // whether the first request has filled it yet.
  logic [tbrl_pkg::RATE_W-1:0]  mir_rate;
  logic [tbrl_pkg::BURST_W-1:0] mir_burst;
  logic [tbrl_pkg::TOKEN_W-1:0] mir_level;
  logic [tbrl_pkg::TIME_W-1:0]  mir_stamp;
  logic                         mir_live;

  logic                         allow_expected[$];   // predicted allowed bit per request
  logic                         want_allowed;
  logic [tbrl_pkg::TIME_W-1:0]  clock_ms;            // latest forward time handed out
  int                           fail_count;
  int                           quiet_cycles;
  int                           hold_left;
  bit                           gaps_on;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Work out the verdict for one request and advance the mirrored bucket.
  function automatic logic admit_request(input logic [tbrl_pkg::TIME_W-1:0] stamp);
    logic [tbrl_pkg::TOKEN_W-1:0] cap;
    logic [tbrl_pkg::TIME_W-1:0]  gap;
    logic [79:0]                  gain;
    logic                         granted;
    cap = tbrl_pkg::TOKEN_W'(32'(mir_burst) * 32'(tbrl_pkg::MILLI_PER_TOKEN));
    if (!mir_live) begin
      // First request ever: fill to the brim and start the clock.
      mir_level = cap;
      mir_stamp = stamp;
      mir_live  = 1'b1;
    end else if (stamp >= mir_stamp) begin
      // Time moved forward or stood still: refill, then clamp. A full or
      // overfull bucket (burst lowered since) snaps to capacity even with
      // zero elapsed time. Backward time skips all of this.
      gap  = stamp - mir_stamp;
      gain = 80'(gap) * 80'(mir_rate);
      if (mir_level >= cap || gain >= 80'(cap - mir_level))
        mir_level = cap;
      else
        mir_level = mir_level + tbrl_pkg::TOKEN_W'(gain);
      mir_stamp = stamp;
    end
    if (mir_level < tbrl_pkg::TOKEN_COST) begin
      granted = 1'b0;
    end else begin
      mir_level = mir_level - tbrl_pkg::TOKEN_COST;
      granted   = 1'b1;
    end
    return granted;
  endfunction

  // Offer one request word; valid stays high afterwards so back-to-back
  // words never toggle it within one step.
  task automatic send_request(input logic [tbrl_pkg::TIME_W-1:0] stamp);
    @(negedge clk);
    while (gaps_on && $urandom_range(99) < 14) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= stamp;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    allow_expected.push_back(admit_request(stamp));
  endtask

  task automatic sender_idle();
    @(negedge clk);
    s_tvalid <= 1'b0;
  endtask

  // Wait out every pending result, then let the pipeline drain.
  task automatic settle_results();
    while (allow_expected.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_register(input logic [tbrl_pkg::CFG_INDEX_W-1:0] idx,
                                input logic [tbrl_pkg::BURST_W-1:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      tbrl_pkg::REG_REFILL_RATE: mir_rate  = val;
      tbrl_pkg::REG_BURST_SIZE:  mir_burst = val;
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Settings change only with the block drained.
  task automatic reconfigure(input logic [tbrl_pkg::RATE_W-1:0] rate,
                             input logic [tbrl_pkg::BURST_W-1:0] burst);
    sender_idle();
    settle_results();
    write_register(tbrl_pkg::REG_REFILL_RATE, rate);
    write_register(tbrl_pkg::REG_BURST_SIZE, burst);
  endtask

  // Reset settings (rate 10, burst 20): first fill, backward time, no gap.
  task automatic test_first_fill();
    send_request(64'd5);
    send_request(64'd0);
    send_request(64'd5);
    send_request(64'd105);
    clock_ms = 64'd105;
  endtask

  // Writes to unused indexes; an alias onto either register would show up
  // as a zero burst or a huge refill on the next two requests.
  task automatic test_spare_index();
    sender_idle();
    settle_results();
    write_register(REG_SPARE_FIRST, '1);
    write_register(REG_SPARE_LAST, '0);
    send_request(64'd105);
    send_request(64'd106);
    clock_ms = 64'd106;
  endtask

  // Lower burst to one token with no refill: clamp at zero elapsed time,
  // then a long wait at rate zero must still find the bucket empty.
  task automatic test_shrunk_burst();
    reconfigure('0, tbrl_pkg::BURST_W'(1));
    send_request(64'd106);
    send_request(64'd106);
    send_request(64'd1_000_000);
    clock_ms = 64'd1_000_000;
  endtask

  // Burst zero gives capacity zero, but a backward time skips the clamp
  // and may still spend what is left over.
  task automatic test_zero_burst();
    reconfigure('1, tbrl_pkg::BURST_W'(3));
    send_request(64'd2_000_001);
    sender_idle();
    settle_results();
    write_register(tbrl_pkg::REG_BURST_SIZE, '0);
    send_request(64'd5);
    send_request(64'd2_000_002);
    clock_ms = 64'd2_000_002;
  endtask

  // Largest settings with overflowing refill products, then smallest
  // nonzero settings around the one-token boundary.
  task automatic test_setting_extremes();
    reconfigure('1, '1);
    send_request(64'h5555_5555_5555_5555);
    send_request(64'hAAAA_AAAA_AAAA_AAAA);
    reconfigure(tbrl_pkg::RATE_W'(1), tbrl_pkg::BURST_W'(1));
    clock_ms = 64'hAAAA_AAAA_AAAA_AAAA;
    send_request(clock_ms + 64'd1);
    send_request(clock_ms + 64'd1001);
    send_request(clock_ms + 64'd2000);
    clock_ms = clock_ms + 64'd2000;
  endtask

  // Mostly a plausible request clock (bursts in the same millisecond,
  // short and long gaps), with some backward and wild timestamps mixed in.
  task automatic run_traffic(input int words);
    logic [tbrl_pkg::TIME_W-1:0] stamp;
    int                          roll;
    for (int i = 0; i < words; i++) begin
      roll = $urandom_range(99);
      if (roll < 38) begin
        stamp = clock_ms;
      end else if (roll < 72) begin
        clock_ms += tbrl_pkg::TIME_W'($urandom_range(1, 40));
        stamp = clock_ms;
      end else if (roll < 86) begin
        clock_ms += tbrl_pkg::TIME_W'($urandom_range(41, 3000));
        stamp = clock_ms;
      end else if (roll < 90) begin
        clock_ms += {$urandom, $urandom} >> $urandom_range(20, 63);
        stamp = clock_ms;
      end else if (roll < 96) begin
        stamp = clock_ms - tbrl_pkg::TIME_W'($urandom_range(1, 100_000));
      end else begin
        stamp = {$urandom, $urandom} % clock_ms;
      end
      send_request(stamp);
    end
  endtask

  // Phases over several settings; one phase runs with no idling on either
  // side and one also pokes a spare register index.
  task automatic test_random_traffic();
    logic [tbrl_pkg::RATE_W-1:0]  rate;
    logic [tbrl_pkg::BURST_W-1:0] burst;
    for (int p = 0; p < 10; p++) begin
      case (p)
        0: begin
          rate  = '0;
          burst = tbrl_pkg::BURST_W'(2);
        end
        1: begin
          rate  = '1;
          burst = tbrl_pkg::BURST_W'(1);
        end
        2: begin
          rate  = tbrl_pkg::RATE_W'(1);
          burst = '1;
        end
        3: begin
          rate  = '1;
          burst = '1;
        end
        8: begin
          rate  = tbrl_pkg::RATE_W'($urandom_range(0, 65535));
          burst = tbrl_pkg::BURST_W'($urandom_range(1, 65535));
        end
        default: begin
          rate  = tbrl_pkg::RATE_W'($urandom_range(1, 300));
          burst = tbrl_pkg::BURST_W'($urandom_range(1, 6));
        end
      endcase
      reconfigure(rate, burst);
      if (p == 6)
        write_register(tbrl_pkg::CFG_INDEX_W'($urandom_range(2, 255)),
                       tbrl_pkg::BURST_W'($urandom));
      gaps_on = (p != 5);
      run_traffic(PHASE_WORDS);
    end
    gaps_on = 1'b1;
  endtask

  // Stall the result side for a long stretch while requests keep coming,
  // so the block backs up and stops taking words; then pause the sender
  // until everything has drained.
  task automatic test_output_backpressure();
    reconfigure(tbrl_pkg::RATE_W'(5), tbrl_pkg::BURST_W'(4));
    sender_idle();
    hold_left = HOLD_CYCLES;
    run_traffic(60);
    sender_idle();
    settle_results();
  endtask

  // Timestamp at its maximum, then back to zero.
  task automatic test_clock_limits();
    reconfigure(tbrl_pkg::RATE_W'(7), tbrl_pkg::BURST_W'(2));
    send_request('1);
    send_request('0);
  endtask

  // Result side: random stalls, or a held-off stretch when requested.
  always @(negedge clk) begin
    if (hold_left > 0) begin
      m_tready <= 1'b0;
      hold_left--;
    end else begin
      m_tready <= !(gaps_on && $urandom_range(99) < 14);
    end
  end

  // Compare every result word against the oldest prediction.
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (allow_expected.size() == 0) begin
        $error("allowed: result word with nothing expected, actual %0b", m_tdata[0]);
        fail_count++;
      end else begin
        want_allowed = allow_expected.pop_front();
        if (m_tdata[0] !== want_allowed) begin
          $error("allowed: expected %0b, actual %0b", want_allowed, m_tdata[0]);
          fail_count++;
        end
        if (m_tdata[7:1] !== 7'd0) begin
          $error("m_tdata pad: expected 0, actual %h", m_tdata[7:1]);
          fail_count++;
        end
      end
    end
  end

  // Abort if no word moves on any channel for too long.
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
        (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  initial begin
    rst       = 1'b1;
    s_tvalid  = 1'b0;
    s_tdata   = '0;
    m_tready  = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    fail_count   = 0;
    quiet_cycles = 0;
    hold_left    = 0;
    gaps_on      = 1'b1;
    clock_ms     = '0;
    // Mirror the reset state of the block.
    mir_rate  = tbrl_pkg::RATE_RESET;
    mir_burst = tbrl_pkg::BURST_W'(20);
    mir_level = '0;
    mir_stamp = '0;
    mir_live  = 1'b0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_first_fill();
    test_spare_index();
    test_shrunk_burst();
    test_zero_burst();
    test_setting_extremes();
    test_random_traffic();
    test_output_backpressure();
    test_clock_limits();

    sender_idle();
    settle_results();
    if (fail_count == 0 && allow_expected.size() == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

endmodule

### token_bucket_request_limiter.f
+incdir+design
design/tbrl_pkg.sv
design/tbrl_cfg.sv
design/tbrl_bucket.sv
design/token_bucket_request_limiter.sv
test/tb_token_bucket_request_limiter.sv
